// ===== hw/rtl/essr_pkg.sv =====
// Package for the escape sequence stream recognizer.
// Holds the sequence ROM image, the byte constants and the status codes.
// It has no dependencies.
`default_nettype none

package essr_pkg;

  localparam int TableRows  = 53;
  localparam int SeqColumns = 5;
  localparam int RowW       = 6;
  localparam int ColW       = 3;

  localparam logic [7:0] PadByte   = 8'hFF;
  localparam logic [7:0] WildByte  = 8'd63;
  localparam logic [7:0] SpaceByte = 8'd32;
  localparam logic [7:0] EscByte   = 8'd27;
  localparam logic [7:0] GsByte    = 8'd29;
  localparam logic [7:0] FmtLow    = 8'd8;
  localparam logic [7:0] FmtHigh   = 8'd13;

  typedef enum logic [1:0] {
    STATUS_NONE  = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_FOUND = 2'd2
  } status_e;

  // Sorted control sequences; 0xFF pads a row, 63 matches any byte.
  localparam logic [7:0] SeqRom [TableRows][SeqColumns] = '{
    '{8'd7,  8'd255, 8'd255, 8'd255, 8'd255}, '{8'd7,  8'd27,  8'd255, 8'd255, 8'd255},
    '{8'd14, 8'd255, 8'd255, 8'd255, 8'd255}, '{8'd20, 8'd255, 8'd255, 8'd255, 8'd255},
    '{8'd27, 8'd7,   8'd10,  8'd50,  8'd7},   '{8'd27, 8'd7,   8'd11,  8'd55,  8'd7},
    '{8'd27, 8'd32,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd33,  8'd0,   8'd32,  8'd63},
    '{8'd27, 8'd33,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd45,  8'd0,   8'd255, 8'd255},
    '{8'd27, 8'd45,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd64,  8'd255, 8'd255, 8'd255},
    '{8'd27, 8'd69,  8'd0,   8'd255, 8'd255}, '{8'd27, 8'd69,  8'd63,  8'd255, 8'd255},
    '{8'd27, 8'd70,  8'd0,   8'd50,  8'd50},  '{8'd27, 8'd71,  8'd0,   8'd255, 8'd255},
    '{8'd27, 8'd71,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd73,  8'd255, 8'd255, 8'd255},
    '{8'd27, 8'd77,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd80,  8'd0,   8'd25,  8'd250},
    '{8'd27, 8'd80,  8'd0,   8'd64,  8'd240}, '{8'd27, 8'd80,  8'd0,   8'd63,  8'd255},
    '{8'd27, 8'd97,  8'd63,  8'd255, 8'd255}, '{8'd27, 8'd99,  8'd63,  8'd63,  8'd255},
    '{8'd27, 8'd100, 8'd63,  8'd255, 8'd255}, '{8'd27, 8'd105, 8'd255, 8'd255, 8'd255},
    '{8'd27, 8'd109, 8'd255, 8'd255, 8'd255}, '{8'd27, 8'd110, 8'd0,   8'd25,  8'd250},
    '{8'd27, 8'd112, 8'd0,   8'd63,  8'd63},  '{8'd27, 8'd112, 8'd1,   8'd63,  8'd63},
    '{8'd27, 8'd112, 8'd32,  8'd63,  8'd63},  '{8'd27, 8'd112, 8'd48,  8'd63,  8'd63},
    '{8'd27, 8'd112, 8'd49,  8'd63,  8'd63},  '{8'd27, 8'd114, 8'd0,   8'd255, 8'd255},
    '{8'd27, 8'd114, 8'd1,   8'd255, 8'd255}, '{8'd27, 8'd114, 8'd48,  8'd255, 8'd255},
    '{8'd27, 8'd114, 8'd49,  8'd255, 8'd255}, '{8'd27, 8'd116, 8'd63,  8'd255, 8'd255},
    '{8'd27, 8'd118, 8'd255, 8'd255, 8'd255}, '{8'd27, 8'd120, 8'd1,   8'd255, 8'd255},
    '{8'd27, 8'd122, 8'd49,  8'd7,   8'd255}, '{8'd29, 8'd35,  8'd63,  8'd255, 8'd255},
    '{8'd29, 8'd47,  8'd63,  8'd255, 8'd255}, '{8'd29, 8'd66,  8'd0,   8'd255, 8'd255},
    '{8'd29, 8'd66,  8'd63,  8'd255, 8'd255}, '{8'd29, 8'd86,  8'd0,   8'd255, 8'd255},
    '{8'd29, 8'd86,  8'd63,  8'd255, 8'd255}, '{8'd29, 8'd86,  8'd48,  8'd255, 8'd255},
    '{8'd29, 8'd86,  8'd49,  8'd255, 8'd255}, '{8'd29, 8'd86,  8'd65,  8'd63,  8'd255},
    '{8'd29, 8'd86,  8'd66,  8'd63,  8'd255}, '{8'd29, 8'd114, 8'd63,  8'd255, 8'd255},
    '{8'd30, 8'd255, 8'd255, 8'd255, 8'd255}
  };

  // Reads one ROM byte; anything outside the table reads as padding.
  function automatic logic [7:0] rom_byte(logic [RowW-1:0] row, logic [ColW-1:0] col);
    logic [7:0] b;
    b = PadByte;
    if ((int'(row) < TableRows) && (int'(col) < SeqColumns)) begin
      b = SeqRom[row][col];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/escape_sequence_stream_recognizer.sv =====
// Top level of the escape sequence stream recognizer.
// Uses essr_pkg for the ROM image, byte constants and status codes.
`default_nettype none

// The recognizer takes one printer data byte per input transaction and
// returns exactly one result transaction per byte: a status of none, busy
// (inside a control sequence) or found, with the matched ROM row when the
// status is found and 0 otherwise. Internally a row window [low, high] over
// a sorted ROM of 53 rows by 5 columns is narrowed for each byte by one
// shared byte comparator under a small sequencer: the low row steps up one
// row per cycle, then the high row steps down one row per cycle, then the
// last non-padding column of a lone remaining row is located one column per
// cycle. A byte therefore passes through an accept step, the two row scans
// that together move the window edges by at most 52 rows, one decision
// step for each scan, the column search and a hand-over step; idle bytes
// and aborts without restart go straight from accept to hand-over. The row
// scans dominate the time per byte; the hand-over waits while the output
// register holds a result not yet taken. Input stall is low only while the
// sequencer is idle; a finished result sits in an output register, so the
// next byte can be accepted while that result still waits to be taken.
module escape_sequence_stream_recognizer
  import essr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [7:0]      in_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           match_status_o,
  output logic [RowW-1:0]      row_found_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCANLO = 5'b00010,
    ST_SCANHI = 5'b00100,
    ST_LAST   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic            seq_q, seq_d;
  logic [ColW-1:0] col_q, col_d;
  logic [ColW-1:0] last_q, last_d;
  logic [RowW-1:0] lo_q, lo_d;
  logic [RowW-1:0] hi_q, hi_d;
  logic [7:0]      byte_q, byte_d;
  status_e         res_status_q, res_status_d;
  logic [RowW-1:0] res_row_q, res_row_d;
  logic            out_valid_q, out_valid_d;
  status_e         out_status_q, out_status_d;
  logic [RowW-1:0] out_row_q, out_row_d;

  logic            in_accept;
  logic            seq_kept;
  logic            start_seq;
  logic [RowW-1:0] unit_row;
  logic [ColW-1:0] unit_col;
  logic [7:0]      unit_ref;
  logic [7:0]      unit_byte;
  logic            unit_eq;
  logic            out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // An escape or group separator drops a running match; any control byte
  // outside the format effector range then opens a new one.
  assign seq_kept  = seq_q && (in_byte_i != EscByte) && (in_byte_i != GsByte);
  assign start_seq = !seq_kept && (in_byte_i < SpaceByte) &&
                     ((in_byte_i < FmtLow) || (in_byte_i > FmtHigh));

  // The shared unit: one ROM read and one byte compare per cycle. The high
  // scan addresses the high row, the column search looks for padding one
  // column past the current last column.
  always_comb begin
    unit_row = lo_q;
    unit_col = col_q;
    unit_ref = byte_q;
    if (state_q == ST_SCANHI) begin
      unit_row = hi_q;
    end
    if (state_q == ST_LAST) begin
      unit_col = last_q + ColW'(1);
      unit_ref = PadByte;
    end
  end

  assign unit_byte = rom_byte(unit_row, unit_col);
  assign unit_eq   = (unit_byte == unit_ref);

  always_comb begin
    state_d      = state_q;
    seq_d        = seq_q;
    col_d        = col_q;
    last_d       = last_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    byte_d       = byte_q;
    res_status_d = res_status_q;
    res_row_d    = res_row_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_row_d    = out_row_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          byte_d       = in_byte_i;
          res_status_d = STATUS_NONE;
          res_row_d    = '0;
          if (start_seq) begin
            seq_d   = 1'b1;
            col_d   = '0;
            lo_d    = '0;
            hi_d    = RowW'(TableRows - 1);
            state_d = ST_SCANLO;
          end else if (!seq_kept) begin
            // Idle byte that opens nothing, or an abort with no restart.
            seq_d   = 1'b0;
            state_d = ST_FINISH;
          end else if (int'(col_q) >= SeqColumns) begin
            // The sequence ran past the last table column.
            seq_d   = 1'b0;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCANLO;
          end
        end
      end
      ST_SCANLO: begin
        if ((lo_q < hi_q) && !unit_eq) begin
          lo_d = lo_q + RowW'(1);
        end else if (unit_eq || (unit_byte == WildByte)) begin
          state_d = ST_SCANHI;
        end else begin
          seq_d        = 1'b0;
          res_status_d = STATUS_NONE;
          state_d      = ST_FINISH;
        end
      end
      ST_SCANHI: begin
        if ((hi_q > lo_q) && !unit_eq) begin
          hi_d = hi_q - RowW'(1);
        end else if (hi_q == lo_q) begin
          last_d  = col_q;
          state_d = ST_LAST;
        end else begin
          col_d        = col_q + ColW'(1);
          res_status_d = STATUS_BUSY;
          state_d      = ST_FINISH;
        end
      end
      ST_LAST: begin
        if ((int'(last_q) < SeqColumns - 1) && !unit_eq) begin
          last_d = last_q + ColW'(1);
        end else begin
          col_d   = col_q + ColW'(1);
          state_d = ST_FINISH;
          if (col_q == last_q) begin
            seq_d        = 1'b0;
            res_status_d = STATUS_FOUND;
            res_row_d    = lo_q;
          end else begin
            res_status_d = STATUS_BUSY;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_row_d    = res_row_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seq_q       <= 1'b0;
      col_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      col_q       <= col_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q       <= last_d;
    byte_q       <= byte_d;
    res_status_q <= res_status_d;
    res_row_q    <= res_row_d;
    out_status_q <= out_status_d;
    out_row_q    <= out_row_d;
  end

  assign out_valid_o    = out_valid_q;
  assign match_status_o = out_status_q;
  assign row_found_o    = out_row_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the escape sequence stream recognizer.
// Depends on essr_pkg for the ROM image, byte constants and status codes.
// A scoreboard predicts each result and compares it field by field.
`timescale 1ns / 100ps

module tb;
  import essr_pkg::*;

  // One predicted result transaction, kept with the byte that caused it.
  typedef struct {
    logic [7:0]      data;
    status_e         status;
    logic [RowW-1:0] row;
  } verdict_t;

  // Directed opening stimulus. In order it covers: BEL then a padding byte
  // (finds row 0), BEL BEL (a bare BEL never completes and then fails),
  // single-byte sequences, a start byte that matches no row, a format byte
  // that must not start a match, ESC aborting and restarting a live match,
  // a GS sequence that ends on a wildcard, and two sequences that run over
  // all five table columns, one of them matching 0xFF against a wildcard.
  localparam logic [7:0] OPENING [25] = '{
    8'd7,  8'd255,
    8'd7,  8'd7,
    8'd14,
    8'd30,
    8'd0,
    8'd10,
    8'd27, 8'd27, 8'd64,
    8'd29, 8'd86, 8'd65, 8'd63,
    8'd27, 8'd112, 8'd0, 8'd255, 8'd0,
    8'd27, 8'd80, 8'd0, 8'd25, 8'd250
  };

  // The quiet stretch at the end and the long receiver hold-off are sized
  // from the longest time that one byte can spend inside the block.
  localparam int TailCycles = 150;
  localparam int HoldCycles = 400;
  localparam int HoldAfter  = 40;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_byte = 8'd0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      match_status;
  logic [RowW-1:0] row_found;

  // Bytes waiting to be offered, and results predicted but not yet seen.
  logic [7:0] pending [$];
  verdict_t   verdicts [$];
  verdict_t   want;

  int  tx_idle_pct;
  int  rx_idle_pct;
  int  bytes_taken = 0;
  int  errors = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // Predictor state: the live match flag, the table column and the window.
  bit               seq_active = 1'b0;
  logic [ColW-1:0]  seq_col = '0;
  int               win_lo = 0;
  int               win_hi = 0;

  escape_sequence_stream_recognizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .match_status_o (match_status),
    .row_found_o    (row_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Everything outside the table reads back as padding.
  function automatic logic [7:0] table_byte(int r, int c);
    if (r < TableRows && c < SeqColumns) begin
      return SeqRom[r][c];
    end
    return PadByte;
  endfunction

  // Advances the predictor by one byte and returns the result it causes.
  function automatic verdict_t recognize_byte(logic [7:0] b);
    verdict_t   v;
    logic [7:0] ent;
    int         last;
    bit         hit;
    v.data   = b;
    v.status = STATUS_NONE;
    v.row    = '0;
    hit      = 1'b0;
    // ESC or GS inside a live match drops it; the byte may then restart.
    if (seq_active && (b == EscByte || b == GsByte)) begin
      seq_active = 1'b0;
    end
    if (!seq_active && b < SpaceByte && (b < FmtLow || b > FmtHigh)) begin
      seq_col    = '0;
      win_lo     = 0;
      win_hi     = TableRows - 1;
      seq_active = 1'b1;
    end
    if (seq_active) begin
      if (int'(seq_col) >= SeqColumns) begin
        seq_active = 1'b0;
      end else begin
        // The scans compare for equality only; the wildcard is honored
        // just in the test of the low row.
        while (win_lo < win_hi && table_byte(win_lo, int'(seq_col)) != b) begin
          win_lo++;
        end
        ent = table_byte(win_lo, int'(seq_col));
        seq_active = (ent == b) || (ent == WildByte);
        if (seq_active) begin
          while (win_hi > win_lo && table_byte(win_hi, int'(seq_col)) != b) begin
            win_hi--;
          end
          if (win_hi == win_lo) begin
            last = int'(seq_col);
            while (last < SeqColumns - 1 && table_byte(win_lo, last + 1) != PadByte) begin
              last++;
            end
            hit = (int'(seq_col) == last);
          end
          seq_col = seq_col + ColW'(1);
        end
      end
    end
    if (hit) begin
      seq_active = 1'b0;
      v.status   = STATUS_FOUND;
      v.row      = RowW'(win_lo);
    end else if (seq_active) begin
      v.status = STATUS_BUSY;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("check failed at %0t: %s", $realtime, what);
  endtask

  // Queues the bytes of one table row, wildcards mostly replaced by random
  // bytes. A cut between 1 and the row's last column keeps only a prefix.
  function automatic int queue_command(int row, int cut);
    int         last;
    int         n;
    logic [7:0] b;
    last = 0;
    while (last < SeqColumns - 1 && SeqRom[row][last + 1] != PadByte) begin
      last++;
    end
    n = (cut > 0 && cut <= last) ? cut : last + 1;
    for (int c = 0; c < n; c++) begin
      b = SeqRom[row][c];
      if (b == WildByte && $urandom_range(3) != 0) begin
        b = 8'($urandom_range(255));
      end
      pending.push_back(b);
    end
    return n;
  endfunction

  // Random traffic: mostly complete sequences with random parameter bytes,
  // then broken sequences and bursts of control or arbitrary bytes, with
  // short runs of plain text between them. Every queued byte counts.
  task automatic queue_random_phase(int quota);
    int counted;
    int row;
    int pick;
    int extra;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(99);
      row  = $urandom_range(TableRows - 1);
      if (pick < 65) begin
        counted += queue_command(row, 0);
        // A lone BEL only completes when a padding byte follows it.
        if (row == 0 && $urandom_range(1) == 1) begin
          pending.push_back(PadByte);
          counted++;
        end
      end else if (pick < 80) begin
        counted += queue_command(row, $urandom_range(1, SeqColumns - 1));
        pending.push_back(8'($urandom_range(255)));
        counted++;
      end else begin
        extra = $urandom_range(1, 4);
        repeat (extra) begin
          pending.push_back(8'(pick < 90 ? $urandom_range(31) : $urandom_range(255)));
        end
        counted += extra;
      end
      if ($urandom_range(3) == 0) begin
        extra = $urandom_range(1, 3);
        repeat (extra) pending.push_back(8'($urandom_range(32, 126)));
        counted += extra;
      end
    end
  endtask

  // Holds the stimulus back until every queued byte has gone in and every
  // predicted result has come out. The small delay lets the edge settle.
  task automatic drain_results();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || in_valid || verdicts.size() != 0);
  endtask

  // Driver: the byte is predicted when its transaction is accepted, so the
  // predictor sees bytes in exactly the order the block does. A new byte is
  // offered only once the previous one has been taken, and it is held
  // steady while the block stalls.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte  <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts.push_back(recognize_byte(in_byte));
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_byte  <= pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall. Once, early in the run, it holds off for a long stretch
  // while the sender keeps offering bytes, so that a finished result sits in
  // the output register and the block has to stall its input.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && bytes_taken >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Monitor: each accepted result transaction is checked against the oldest
  // prediction. The outputs are read at the edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (verdicts.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d row %0d",
                                  match_status, row_found));
      end else begin
        want = verdicts.pop_front();
        if (match_status !== want.status) begin
          report_mismatch($sformatf("byte %0d: status %0d, expected %0d",
                                    want.data, match_status, want.status));
        end
        if (row_found !== want.row) begin
          report_mismatch($sformatf("byte %0d: row %0d, expected %0d",
                                    want.data, row_found, want.row));
        end
      end
    end
  end

  // Stimulus and end of run. The three phases change who idles: first the
  // receiver mostly, then the sender mostly, then neither. Each phase waits
  // for every predicted result before the next one starts.
  initial begin
    tx_idle_pct = 6;
    rx_idle_pct = 81;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) pending.push_back(OPENING[i]);
    queue_random_phase(150);
    drain_results();

    tx_idle_pct = 81;
    rx_idle_pct = 6;
    queue_random_phase(150);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_phase(150);
    drain_results();

    // Leave room for a stray result to show up after the last expected one.
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/essr_pkg.sv
hw/rtl/escape_sequence_stream_recognizer.sv
test/tb.sv
